>>> src/pidpmd_pkg.sv
// shared widths, register indexes and reset values for the pid position motor drive
`timescale 1ns / 1ps
`default_nettype none
package pidpmd_pkg;

    localparam int POSITION_WIDTH = 16;
    localparam int SUM_WIDTH      = 32;
    localparam int ERR_W          = POSITION_WIDTH + 1;
    localparam int GAIN_W         = 10;
    localparam int LIMIT_W        = 10;
    localparam int BAND_W         = 8;
    localparam int COUNT_W        = 8;
    localparam int DRIVE_W        = SUM_WIDTH + GAIN_W + 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_OUTPUT_LIMIT   = 3'd3,
        CFG_SETTLE_BAND    = 3'd4,
        CFG_SETTLE_TICKS   = 3'd5,
        CFG_STOP_ON_SETTLE = 3'd6
    } cfg_idx_t;

    localparam logic [GAIN_W-1:0]  GAIN_P_RESET         = 10'd100;
    localparam logic [GAIN_W-1:0]  GAIN_I_RESET         = 10'd0;
    localparam logic [GAIN_W-1:0]  GAIN_D_RESET         = 10'd0;
    localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RESET   = 10'd512;
    localparam logic [BAND_W-1:0]  SETTLE_BAND_RESET    = 8'd5;
    localparam logic [COUNT_W-1:0] SETTLE_TICKS_RESET   = 8'd10;
    localparam logic               STOP_ON_SETTLE_RESET = 1'b1;

endpackage
`default_nettype wire

>>> src/pid_position_motor_drive_unit.sv
// pid position controller with saturated drive, settle detection and stop-on-settle
//
// usage
//   input channel: s_valid/s_ready carry one control tick per beat: target and
//   measured encoder position plus a start_move flag that clears the loop state
//   before the tick is worked on
//   result channel: m_valid/m_ready carry one beat per tick: direction bits,
//   duty magnitude, in_band and settled
//   configuration: cfg_we writes cfg_data into the register named by cfg_index
//   (gains, drive limit, settle band, settle ticks, stop mode); write only when
//   no tick is in flight; unknown indexes are ignored
// timing
//   a beat taken on s_ passes through two registers (input register, then result
//   register) before it appears on m_; one beat per cycle sustained while m_ready
//   is high; the whole pid update, including the error sum, is combinational
//   between the two registers, so the next tick sees the updated loop state
// reset
//   aresetn low clears the valid flags of both register stages and the loop
//   state, and restores the register defaults
// back-pressure
//   while m_ready is low the result holds, the input register keeps its beat
//   and s_ready drops once it is full; no beat is lost
`timescale 1ns / 1ps
`default_nettype none
module pid_position_motor_drive_unit (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    // configuration write port
    input  wire logic                                      cfg_we,
    input  wire logic [pidpmd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [pidpmd_pkg::CFG_DATA_W-1:0]         cfg_data,
    // input channel
    input  wire logic                                      s_valid,
    output      logic                                      s_ready,
    input  wire logic signed [pidpmd_pkg::POSITION_WIDTH-1:0] s_target_position,
    input  wire logic signed [pidpmd_pkg::POSITION_WIDTH-1:0] s_current_position,
    input  wire logic                                      s_start_move,
    // result channel
    output      logic                                      m_valid,
    input  wire logic                                      m_ready,
    output      logic                                      m_drive_forward,
    output      logic                                      m_drive_reverse,
    output      logic [pidpmd_pkg::LIMIT_W-1:0]            m_duty,
    output      logic                                      m_in_band,
    output      logic                                      m_settled
);
    import pidpmd_pkg::*;

    // configuration registers
    logic [GAIN_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LIMIT_W-1:0] output_limit_reg;
    logic [BAND_W-1:0]  settle_band_reg;
    logic [COUNT_W-1:0] settle_ticks_reg;
    logic               stop_on_settle_reg;

    // input register stage
    logic                             in_valid_reg;
    logic signed [POSITION_WIDTH-1:0] tgt_reg, cur_reg;
    logic                             start_reg;

    // loop state
    logic signed [SUM_WIDTH-1:0] error_sum_reg, error_sum_next;
    logic signed [ERR_W-1:0]     prev_error_reg, prev_error_next;
    logic [COUNT_W-1:0]          settle_count_reg, settle_count_next;
    logic                        move_done_reg, move_done_next;

    // result register stage
    logic               out_valid_reg;
    logic               fwd_reg, rev_reg, band_reg, settled_reg;
    logic [LIMIT_W-1:0] duty_reg;

    logic advance;

    // the input register drains into the result register when that one is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg         <= GAIN_P_RESET;
            gain_i_reg         <= GAIN_I_RESET;
            gain_d_reg         <= GAIN_D_RESET;
            output_limit_reg   <= OUTPUT_LIMIT_RESET;
            settle_band_reg    <= SETTLE_BAND_RESET;
            settle_ticks_reg   <= SETTLE_TICKS_RESET;
            stop_on_settle_reg <= STOP_ON_SETTLE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GAIN_P:         gain_p_reg         <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:         gain_i_reg         <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:         gain_d_reg         <= cfg_data[GAIN_W-1:0];
                CFG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_SETTLE_BAND:    settle_band_reg    <= cfg_data[BAND_W-1:0];
                CFG_SETTLE_TICKS:   settle_ticks_reg   <= cfg_data[COUNT_W-1:0];
                CFG_STOP_ON_SETTLE: stop_on_settle_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            tgt_reg   <= s_target_position;
            cur_reg   <= s_current_position;
            start_reg <= s_start_move;
        end
    end

    // ---------------- tick datapath ----------------
    logic signed [ERR_W-1:0]     err;
    logic [ERR_W-1:0]            err_mag;
    logic                        band;
    logic [COUNT_W-1:0]          need;
    logic signed [SUM_WIDTH-1:0] sum_c;
    logic signed [ERR_W-1:0]     prev_c;
    logic [COUNT_W-1:0]          count_c, count_upd;
    logic                        done_c, hold, settle_now;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic signed [ERR_W:0]       err_delta;
    logic signed [GAIN_W+ERR_W:0]       p_prod;
    logic signed [GAIN_W+SUM_WIDTH:0]   i_prod;
    logic signed [GAIN_W+ERR_W+1:0]     d_prod;
    logic signed [DRIVE_W-1:0]   drive_raw, lim_pos, lim_neg, drive_sat, drive, drive_abs;

    always_comb begin
        err     = ERR_W'(tgt_reg) - ERR_W'(cur_reg);
        err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        band    = err_mag <= ERR_W'(settle_band_reg);
        // a settle count of zero behaves as one
        need    = (settle_ticks_reg == '0) ? COUNT_W'(1) : settle_ticks_reg;

        // start_move clears the loop state ahead of this tick
        sum_c   = start_reg ? '0 : error_sum_reg;
        prev_c  = start_reg ? '0 : prev_error_reg;
        count_c = start_reg ? '0 : settle_count_reg;
        done_c  = start_reg ? 1'b0 : move_done_reg;

        hold = done_c && stop_on_settle_reg;

        // saturating in-band tick counter
        if (!band) begin
            count_upd = '0;
        end else if (count_c == {COUNT_W{1'b1}}) begin
            count_upd = count_c;
        end else begin
            count_upd = count_c + COUNT_W'(1);
        end
        settle_now = stop_on_settle_reg && (count_upd >= need);

        // saturating error sum
        sum_wide = {sum_c[SUM_WIDTH-1], sum_c} + (SUM_WIDTH+1)'(err);
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                          : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_WIDTH-1:0];
        end

        // exact pid sum, gains zero-extended to signed
        err_delta = (ERR_W+1)'(err) - (ERR_W+1)'(prev_c);
        p_prod    = $signed({1'b0, gain_p_reg}) * err;
        i_prod    = $signed({1'b0, gain_i_reg}) * sum_sat;
        d_prod    = $signed({1'b0, gain_d_reg}) * err_delta;
        drive_raw = DRIVE_W'(p_prod) + DRIVE_W'(i_prod) + DRIVE_W'(d_prod);

        lim_pos = $signed(DRIVE_W'(output_limit_reg));
        lim_neg = -lim_pos;
        if (drive_raw > lim_pos) begin
            drive_sat = lim_pos;
        end else if (drive_raw < lim_neg) begin
            drive_sat = lim_neg;
        end else begin
            drive_sat = drive_raw;
        end

        // defaults: motor stopped, state frozen
        error_sum_next    = sum_c;
        prev_error_next   = prev_c;
        settle_count_next = count_c;
        move_done_next    = done_c;
        drive             = '0;
        if (!hold) begin
            settle_count_next = count_upd;
            if (settle_now) begin
                move_done_next = 1'b1;
            end else begin
                error_sum_next  = sum_sat;
                prev_error_next = err;
                drive           = drive_sat;
            end
        end
        drive_abs = drive[DRIVE_W-1] ? -drive : drive;
    end

    // ---------------- loop state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg    <= '0;
            prev_error_reg   <= '0;
            settle_count_reg <= '0;
            move_done_reg    <= 1'b0;
        end else if (advance) begin
            error_sum_reg    <= error_sum_next;
            prev_error_reg   <= prev_error_next;
            settle_count_reg <= settle_count_next;
            move_done_reg    <= move_done_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fwd_reg     <= !drive[DRIVE_W-1] && (drive != '0);
            rev_reg     <= drive[DRIVE_W-1];
            duty_reg    <= drive_abs[LIMIT_W-1:0];
            band_reg    <= band;
            settled_reg <= move_done_next || (settle_count_next >= need);
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_drive_forward = fwd_reg;
    assign m_drive_reverse = rev_reg;
    assign m_duty          = duty_reg;
    assign m_in_band       = band_reg;
    assign m_settled       = settled_reg;

    // ---------------- assertions ----------------
    // a stalled result blocks the state update
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> ($stable(error_sum_reg) && $stable(move_done_reg)))
        else $error("loop state changed while result stalled");

    // direction bits are exclusive on a delivered beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_drive_forward && m_drive_reverse))
        else $error("forward and reverse both set");

    // no direction means no duty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_drive_forward && !m_drive_reverse) |-> (m_duty == '0))
        else $error("duty nonzero with motor stopped");

    // a held done in stop mode forces a stopped, settled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && hold) |=> (m_settled && !m_drive_forward && !m_drive_reverse))
        else $error("held move not reported as stopped and settled");

endmodule
`default_nettype wire
